// ----- hdl/sobel_pkg.sv -----
// Package: state type, command and register codes, and fixed field widths of the Sobel edge magnitude block.
package sobel_pkg;

  localparam int CfgWidth  = 11;
  localparam int PixWidth  = 24;
  localparam int ChanWidth = 8;
  localparam int NormWidth = 21;
  localparam int Taps      = 9;

  localparam logic [0:0] CmdPixel = 1'b0;
  localparam logic [0:0] CmdFlush = 1'b1;

  localparam logic [0:0] RegFrameWidth  = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_ROUND,
    ST_OUT
  } state_t;

endpackage

// ----- hdl/sobel_edge_magnitude_rgb.sv -----
// Top level: 3x3 Sobel edge magnitude on an RGB raster stream.
// One item at a time: an item that yields no result only passes the write state; one that yields
// a result goes through write, neighbor reads from the single-port ring, gradient, square,
// 11-step square root and rounding before out_valid rises, and then waits while out_stall is high.
// The ring memory port and the bit-pair square root loop set the length of this sequence.
// Synchronous reset clears control and positions and sets the sizes to 1024 x 1024; ring is not cleared.
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  command,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_edge,
  output logic [7:0]  green_edge,
  output logic [7:0]  blue_edge,
  output logic        frame_end
);

  localparam int RING = 2 * MAX_WIDTH + 3;
  localparam int AW   = $clog2(RING);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int CW   = sobel_pkg::CfgWidth;
  localparam int NW   = sobel_pkg::NormWidth;

  sobel_pkg::state_t state, state_next;

  logic [CW-1:0] frame_width, frame_height;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [TW-1:0] total;

  logic [TW-1:0] t, q;
  logic [AW-1:0] wp, qp;
  logic [WW-1:0] ocol;
  logic [HW-1:0] orow;

  logic [0:0]  cmd_q;
  logic [23:0] din;
  logic [3:0]  k, kd;
  logic        kv, rd_pend;
  logic [23:0] win [sobel_pkg::Taps];

  logic [9:0]    ax [3];
  logic [9:0]    ay [3];
  logic [NW-1:0] rem [3];
  logic [NW-1:0] root [3];
  logic [NW-1:0] bitm;

  logic cfg_wr, t_lt_total, t_ge_w1, drop;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == sobel_pkg::RegFrameHeight) ? 32'(frame_height)
                                                         : 32'(frame_width);

  // Clamp sizes to the legal range
  always_comb begin
    if (frame_width == '0) w_eff = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(frame_width);
    if (frame_height == '0) h_eff = HW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(frame_height);
  end

  assign total      = TW'(w_eff) * TW'(h_eff);
  assign t_lt_total = t < total;
  assign t_ge_w1    = t >= (TW'(w_eff) + TW'(1));
  assign drop       = t_lt_total && (cmd_q == sobel_pkg::CmdFlush);

  // Neighbor address and bounds for tap k
  logic [1:0]           dr, dc;
  logic signed [AW+1:0] nsum;
  logic [AW-1:0]        naddr;
  logic                 nvalid;

  always_comb begin
    if (k >= 4'd6) dr = 2'd2;
    else if (k >= 4'd3) dr = 2'd1;
    else dr = 2'd0;
    dc = 2'(k - 4'(3 * dr));
    nsum = $signed({2'b00, qp}) + $signed((AW+2)'(dc)) - $signed((AW+2)'(1));
    if (dr == 2'd0) nsum = nsum - $signed((AW+2)'(w_eff));
    else if (dr == 2'd2) nsum = nsum + $signed((AW+2)'(w_eff));
    if (nsum < 0) nsum = nsum + $signed((AW+2)'(RING));
    else if (nsum >= $signed((AW+2)'(RING))) nsum = nsum - $signed((AW+2)'(RING));
    naddr  = nsum[AW-1:0];
    nvalid = 1'b1;
    if (dr == 2'd0 && orow == '0) nvalid = 1'b0;
    if (dr == 2'd2 && (HW+1)'(orow) + (HW+1)'(1) >= (HW+1)'(h_eff)) nvalid = 1'b0;
    if (dc == 2'd0 && ocol == '0) nvalid = 1'b0;
    if (dc == 2'd2 && (WW+1)'(ocol) + (WW+1)'(1) >= (WW+1)'(w_eff)) nvalid = 1'b0;
  end

  // Line ring memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [23:0]   ram_rdata;

  assign ram_we   = (state == sobel_pkg::ST_WRITE) && t_lt_total && !drop;
  assign ram_addr = (state == sobel_pkg::ST_WRITE) ? wp : naddr;

  sobel_ram #(.WIDTH(sobel_pkg::PixWidth), .DEPTH(RING)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (din),
    .rdata (ram_rdata)
  );

  // Gradients per channel
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gx[c] = $signed({4'b0, win[2][8*c +: 8]}) + $signed({3'b0, win[5][8*c +: 8], 1'b0})
            + $signed({4'b0, win[8][8*c +: 8]}) - $signed({4'b0, win[0][8*c +: 8]})
            - $signed({3'b0, win[3][8*c +: 8], 1'b0}) - $signed({4'b0, win[6][8*c +: 8]});
      gy[c] = $signed({4'b0, win[6][8*c +: 8]}) + $signed({3'b0, win[7][8*c +: 8], 1'b0})
            + $signed({4'b0, win[8][8*c +: 8]}) - $signed({4'b0, win[0][8*c +: 8]})
            - $signed({3'b0, win[1][8*c +: 8], 1'b0}) - $signed({4'b0, win[2][8*c +: 8]});
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sobel_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    unique case (state)
      sobel_pkg::ST_IDLE:   if (in_valid) state_next = sobel_pkg::ST_WRITE;
      sobel_pkg::ST_WRITE: begin
        if (drop || !t_ge_w1) state_next = sobel_pkg::ST_IDLE;
        else state_next = sobel_pkg::ST_READ;
      end
      sobel_pkg::ST_READ:   if (k == 4'd9) state_next = sobel_pkg::ST_GRAD;
      sobel_pkg::ST_GRAD:   state_next = sobel_pkg::ST_SQUARE;
      sobel_pkg::ST_SQUARE: state_next = sobel_pkg::ST_ROOT;
      sobel_pkg::ST_ROOT:   if (bitm == NW'(1)) state_next = sobel_pkg::ST_ROUND;
      sobel_pkg::ST_ROUND:  state_next = sobel_pkg::ST_OUT;
      sobel_pkg::ST_OUT:    if (!out_stall) state_next = sobel_pkg::ST_IDLE;
      default:              state_next = sobel_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state != sobel_pkg::ST_IDLE);
  assign out_valid = (state == sobel_pkg::ST_OUT);

  // Sizes and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CW'(1024);
      frame_height <= CW'(1024);
      t <= '0; q <= '0; wp <= '0; qp <= '0; ocol <= '0; orow <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == sobel_pkg::RegFrameWidth) frame_width <= pwdata[CW-1:0];
      else frame_height <= pwdata[CW-1:0];
      t <= '0; q <= '0; wp <= '0; qp <= '0; ocol <= '0; orow <= '0;
    end else if (state == sobel_pkg::ST_WRITE && !drop) begin
      t  <= t + TW'(1);
      wp <= (wp == AW'(RING - 1)) ? '0 : wp + AW'(1);
    end else if (state == sobel_pkg::ST_ROUND) begin
      if (q + TW'(1) >= total) begin
        t <= '0; q <= '0; wp <= '0; qp <= '0; ocol <= '0; orow <= '0;
      end else begin
        q  <= q + TW'(1);
        qp <= (qp == AW'(RING - 1)) ? '0 : qp + AW'(1);
        if ((WW+1)'(ocol) + (WW+1)'(1) >= (WW+1)'(w_eff)) begin
          ocol <= '0;
          orow <= orow + HW'(1);
        end else begin
          ocol <= ocol + WW'(1);
        end
      end
    end
  end

  // Tap read sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      rd_pend <= 1'b0;
    end else if (state == sobel_pkg::ST_READ) begin
      k       <= (k == 4'd9) ? '0 : k + 4'd1;
      rd_pend <= (k != 4'd9);
    end else begin
      k       <= '0;
      rd_pend <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state == sobel_pkg::ST_IDLE && in_valid) begin
      cmd_q <= command;
      din   <= {blue_in, green_in, red_in};
    end
    kd <= k;
    kv <= nvalid;
    if (rd_pend) begin
      win[kd] <= kv ? ram_rdata : '0;
    end
    if (state == sobel_pkg::ST_GRAD) begin
      for (int c = 0; c < 3; c++) begin
        ax[c] <= 10'((gx[c] < 0) ? -gx[c] : gx[c]);
        ay[c] <= 10'((gy[c] < 0) ? -gy[c] : gy[c]);
      end
    end
    if (state == sobel_pkg::ST_SQUARE) begin
      for (int c = 0; c < 3; c++) begin
        rem[c]  <= NW'({10'b0, ax[c]} * {10'b0, ax[c]}) + NW'({10'b0, ay[c]} * {10'b0, ay[c]});
        root[c] <= '0;
      end
      bitm <= NW'(1) << (NW - 1);
    end
    if (state == sobel_pkg::ST_ROOT) begin
      for (int c = 0; c < 3; c++) begin
        if ({1'b0, rem[c]} >= {1'b0, root[c]} + {1'b0, bitm}) begin
          rem[c]  <= rem[c] - root[c] - bitm;
          root[c] <= (root[c] >> 1) + bitm;
        end else begin
          root[c] <= root[c] >> 1;
        end
      end
      bitm <= bitm >> 2;
    end
    if (state == sobel_pkg::ST_ROUND) begin
      logic [NW-1:0] r [3];
      for (int c = 0; c < 3; c++) begin
        r[c] = root[c] + NW'(rem[c] > root[c]);
      end
      red_edge   <= (r[0] > NW'(255)) ? 8'd255 : r[0][7:0];
      green_edge <= (r[1] > NW'(255)) ? 8'd255 : r[1][7:0];
      blue_edge  <= (r[2] > NW'(255)) ? 8'd255 : r[2][7:0];
      frame_end  <= (q + TW'(1) >= total);
    end
  end

  // Checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a result waits");
  a_accept_write: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == sobel_pkg::ST_WRITE)
    else $error("accepted item not written");
  a_read_span: assert property (@(posedge clk) disable iff (rst)
    (state == sobel_pkg::ST_GRAD) |-> $past(k) == 4'd9)
    else $error("gradient started before all taps read");

endmodule

// ----- hdl/sobel_ram.sv -----
// Generic single-port RAM with registered read data.
module sobel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2051
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- bench/tb_sobel_edge_magnitude_rgb.sv -----
// Testbench for the RGB Sobel edge magnitude block: stimulus, prediction and result checking.
module tb_sobel_edge_magnitude_rgb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 60;
  localparam int PressureCycles = 400;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_px_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [0:0]  command;
  logic [7:0]  red_in, green_in, blue_in;
  logic        out_valid, out_stall;
  logic [7:0]  red_edge, green_edge, blue_edge;
  logic        frame_end;

  // Predictor state: raw sizes, raster positions, current frame pixels.
  logic [10:0] width_reg, height_reg;
  int          in_col, in_row, out_pos;
  logic [23:0] frame_px [0:1023];
  logic [23:0] win [0:8];
  edge_px_t    pending_edges [$];

  int  errors = 0;
  int  cycles = 0;
  bit  hold_req = 1'b0;
  bit  quiet = 1'b0;

  sobel_edge_magnitude_rgb DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_sobel_edge_magnitude_rgb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (quiet || sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int eff_size(logic [10:0] v);
    if (v < 1) return 1;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  // Rounded, clamped gradient magnitude of one channel of the window.
  function automatic logic [7:0] chan_edge(int sh);
    int p [0:8];
    int gx, gy, n, rt, b;
    for (int k = 0; k < 9; k++) p[k] = int'((win[k] >> sh) & 24'hFF);
    gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
    gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
    n = gx * gx + gy * gy;
    rt = 0;
    for (b = 2048; b > 0; b = b >> 1)
      if ((rt + b) * (rt + b) <= n) rt = rt + b;
    if (n > rt * rt + rt) rt++;
    return (rt > 255) ? 8'd255 : 8'(rt);
  endfunction

  // Advance the predictor by one accepted transfer.
  task automatic predict_edge(logic [0:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, total, t, q, orow, ocol, nr, nc;
    edge_px_t e;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    total = w * h;
    t = in_row * w + in_col;
    if (t < total) begin
      if (cmd == sobel_pkg::CmdFlush) return;
      frame_px[t] = {b, g, r};
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (t < w + 1) return;
    q = out_pos;
    orow = q / w;
    ocol = q % w;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = orow + dr;
        nc = ocol + dc;
        if (nr >= 0 && nr < h && nc >= 0 && nc < w)
          win[(dr + 1) * 3 + dc + 1] = frame_px[nr * w + nc];
        else win[(dr + 1) * 3 + dc + 1] = '0;
      end
    end
    e.red = chan_edge(0);
    e.green = chan_edge(8);
    e.blue = chan_edge(16);
    e.last = 1'b0;
    out_pos++;
    if (q + 1 >= total) begin
      e.last = 1'b1;
      in_col = 0;
      in_row = 0;
      out_pos = 0;
    end
    pending_edges.push_back(e);
  endtask

  // Offer one item after a random gap; predict once the transfer happens.
  task automatic send_item(logic [0:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_edge(cmd, r, g, b);
  endtask

  task automatic send_pixel();
    send_item(sobel_pkg::CmdPixel, pick_chan(), pick_chan(), pick_chan());
  endtask

  // Flush slot: mostly flush commands, sometimes a pixel after the frame.
  task automatic send_flush();
    send_item(($urandom_range(0, 3) == 0) ? sobel_pkg::CmdPixel : sobel_pkg::CmdFlush,
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait for the block to go quiet.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_edges.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write (setup, access) followed by a read back.
  task automatic write_reg(logic [0:0] idx, logic [10:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {21'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == sobel_pkg::RegFrameWidth) width_reg = value;
    else height_reg = value;
    in_col = 0;
    in_row = 0;
    out_pos = 0;
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[10:0] !== value) begin
      $display("%0t: register %0d read back expected %0d actual %0d", $time, idx, value,
               prdata[10:0]);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_size(logic [10:0] w, logic [10:0] h);
    write_reg(sobel_pkg::RegFrameWidth, w);
    write_reg(sobel_pkg::RegFrameHeight, h);
  endtask

  // Frame at current size: pixels, early flushes if asked, then enough flush slots to drain.
  task automatic run_frame(bit early_flush);
    int w, total;
    w = eff_size(width_reg);
    total = w * eff_size(height_reg);
    for (int i = 0; i < total; i++) begin
      if (early_flush && $urandom_range(0, 9) == 0)
        send_item(sobel_pkg::CmdFlush, 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel();
    end
    for (int i = 0; i <= w; i++) send_flush();
  endtask

  // Tiny frames with extreme pixels, flushes inside and after the frame.
  task automatic test_directed();
    set_size(11'd3, 11'd3);
    send_item(sobel_pkg::CmdFlush, 8'hFF, 8'hFF, 8'hFF);
    send_item(sobel_pkg::CmdPixel, 8'd255, 8'd0, 8'd255);
    send_item(sobel_pkg::CmdPixel, 8'd0, 8'd255, 8'd0);
    send_item(sobel_pkg::CmdFlush, 8'h00, 8'h00, 8'h00);
    send_item(sobel_pkg::CmdPixel, 8'd255, 8'd255, 8'd0);
    send_item(sobel_pkg::CmdPixel, 8'd0, 8'd0, 8'd255);
    send_item(sobel_pkg::CmdPixel, 8'd255, 8'd0, 8'd0);
    send_item(sobel_pkg::CmdPixel, 8'd0, 8'd255, 8'd255);
    send_item(sobel_pkg::CmdPixel, 8'd255, 8'd255, 8'd255);
    send_item(sobel_pkg::CmdPixel, 8'd0, 8'd0, 8'd0);
    send_item(sobel_pkg::CmdPixel, 8'd255, 8'd0, 8'd255);
    send_item(sobel_pkg::CmdPixel, 8'd9, 8'd9, 8'd9);
    send_item(sobel_pkg::CmdFlush, 8'hAA, 8'h55, 8'hAA);
    send_item(sobel_pkg::CmdPixel, 8'h55, 8'hAA, 8'h55);
    send_item(sobel_pkg::CmdFlush, 8'h00, 8'h00, 8'h00);
    drain();
    set_size(11'd1, 11'd1);
    run_frame(1'b0);
    drain();
  endtask

  // Size extremes, including saturation of zero and oversize values; large frames cut short.
  task automatic test_size_corners();
    set_size(11'd1, 11'd1024);
    repeat (40) send_pixel();
    drain();
    set_size(11'd0, 11'd2047);
    repeat (30) send_pixel();
    drain();
    set_size(11'd2047, 11'd0);
    repeat (20) send_pixel();
    drain();
    set_size(11'd0, 11'd0);
    run_frame(1'b0);
    drain();
  endtask

  // Abort a frame partway with a register write, then run a full frame.
  task automatic test_restart();
    set_size(11'd6, 11'd4);
    repeat (10) send_pixel();
    drain();
    write_reg(sobel_pkg::RegFrameWidth, 11'd5);
    run_frame(1'b0);
    drain();
  endtask

  // Hold the receiver off while the sender keeps offering.
  task automatic test_pressure();
    set_size(11'd8, 11'd4);
    hold_req = 1'b1;
    run_frame(1'b0);
    drain();
  endtask

  // Random frame sizes and content; some frames cut short by a size change.
  task automatic test_random();
    int sent, w, h, cut;
    sent = 0;
    while (sent < 330) begin
      quiet = (sent < 80);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      set_size(11'(w), 11'(h));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, w * h);
        repeat (cut) send_pixel();
        sent += cut;
        drain();
      end else begin
        run_frame(1'b1);
        sent += w * h + w + 1;
        drain();
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver stall: random gaps, plus one long hold-off on request.
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (PressureCycles) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        gap = pick_gap();
        repeat (gap) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each output transfer with the oldest expected edge pixel.
  always @(posedge clk) begin
    edge_px_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{red_edge, green_edge, blue_edge, frame_end};
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected output actual r=%0d g=%0d b=%0d end=%0d", $time,
                 got.red, got.green, got.blue, got.last);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (got !== want) begin
          $display({"%0t: edge mismatch expected r=%0d g=%0d b=%0d end=%0d",
                    " actual r=%0d g=%0d b=%0d end=%0d"},
                   $time, want.red, want.green, want.blue, want.last,
                   got.red, got.green, got.blue, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; command = sobel_pkg::CmdPixel; red_in = '0; green_in = '0; blue_in = '0;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    in_col = 0; in_row = 0; out_pos = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_size_corners();
    test_restart();
    test_pressure();
    test_random();
    if (errors == 0) begin
      $display("tb_sobel_edge_magnitude_rgb: clean");
    end else begin
      $display("tb_sobel_edge_magnitude_rgb: errors");
    end
    $finish;
  end

endmodule
